>>> rtl/drtfl_pkg.sv
`timescale 1ns / 1ps

package drtfl_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 7;
    localparam int DAY_W    = 7;
    localparam int AMOUNT_W = 48;
    localparam int LIMIT_W  = 20;
    localparam int STATUS_W = 3;
    localparam int PROD_W   = 64;
    localparam int KEY_W    = 23;
    localparam int ENTRY_W  = KEY_W + AMOUNT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_DATE  = 3'd1,
        ST_NEGATIVE  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_NO_PRIOR  = 3'd4,
        ST_DUPLICATE = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic    latch_in;
        logic    srch_init;
        logic    srch_rd;
        logic    srch_cmp;
        logic    sh_init;
        logic    sh_rd;
        logic    sh_wr;
        logic    ins_wr;
        logic    mul_init;
        logic    mul_step;
        logic    emit;
        logic    prod_en;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic bad_date;
        logic negative;
        logic too_large;
        logic full;
        logic is_query;
        logic srch_done;
        logic dup;
        logic found;
        logic shift_done;
        logic mul_done;
        logic out_busy;
    } sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/drtfl_in_if.sv
`timescale 1ns / 1ps

interface drtfl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [drtfl_pkg::YEAR_W-1:0]        year;
    logic [drtfl_pkg::MONTH_W-1:0]       month;
    logic [drtfl_pkg::DAY_W-1:0]         day;
    logic signed [drtfl_pkg::AMOUNT_W-1:0] amount;

    modport source (output valid, opcode, year, month, day, amount, input ready);
    modport sink   (input valid, opcode, year, month, day, amount, output ready);
endinterface

>>> rtl/drtfl_out_if.sv
`timescale 1ns / 1ps

interface drtfl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [drtfl_pkg::STATUS_W-1:0]        status;
    logic signed [drtfl_pkg::PROD_W-1:0]   product;

    modport source (output valid, status, product, input ready);
    modport sink   (input valid, status, product, output ready);
endinterface

>>> rtl/drtfl_cfg_if.sv
`timescale 1ns / 1ps

interface drtfl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drtfl_pkg::LIMIT_W-1:0]  query_limit;

    modport source (output valid, query_limit, input ready);
    modport sink   (input valid, query_limit, output ready);
endinterface

>>> rtl/drtfl_ctrl.sv
`timescale 1ns / 1ps

module drtfl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  drtfl_pkg::sts_t   sts,
    output drtfl_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_SRD   = 9'b000000100,
        S_SCMP  = 9'b000001000,
        S_SHRD  = 9'b000010000,
        S_SHWR  = 9'b000100000,
        S_MUL   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_INS   = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    drtfl_pkg::status_t  status_reg, status_next;
    logic                prod_en_reg, prod_en_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            status_reg  <= drtfl_pkg::ST_OK;
            prod_en_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            prod_en_reg <= prod_en_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        prod_en_next = prod_en_reg;
        cmd          = '0;
        cmd.status   = status_reg;
        cmd.prod_en  = prod_en_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    prod_en_next = 1'b0;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.bad_date)
                begin
                    status_next = drtfl_pkg::ST_BAD_DATE;
                    state_next  = S_EMIT;
                end
                else if (sts.negative)
                begin
                    status_next = drtfl_pkg::ST_NEGATIVE;
                    state_next  = S_EMIT;
                end
                else if (sts.is_query && sts.too_large)
                begin
                    status_next = drtfl_pkg::ST_TOO_LARGE;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.srch_init = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_SRD:
            begin
                if (!sts.srch_done)
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SCMP;
                end
                else if (sts.is_query)
                begin
                    if (!sts.found)
                    begin
                        status_next = drtfl_pkg::ST_NO_PRIOR;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        cmd.mul_init = 1'b1;
                        state_next   = S_MUL;
                    end
                end
                else
                begin
                    priority if (sts.dup)
                    begin
                        status_next = drtfl_pkg::ST_DUPLICATE;
                        state_next  = S_EMIT;
                    end
                    else if (sts.full)
                    begin
                        status_next = drtfl_pkg::ST_FULL;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        cmd.sh_init = 1'b1;
                        state_next  = S_SHRD;
                    end
                end
            end
            S_SCMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = S_SRD;
            end
            S_SHRD:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHRD;
            end
            S_INS:
            begin
                cmd.ins_wr  = 1'b1;
                status_next = drtfl_pkg::ST_OK;
                state_next  = S_EMIT;
            end
            S_MUL:
            begin
                if (sts.mul_done)
                begin
                    status_next  = drtfl_pkg::ST_OK;
                    prod_en_next = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/drtfl_dp.sv
`timescale 1ns / 1ps

module drtfl_dp #(
    parameter int TABLE_ENTRIES = drtfl_pkg::TABLE_ENTRIES_DEF,
    parameter int FRACTION_BITS = drtfl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_opcode,
    input  logic [drtfl_pkg::YEAR_W-1:0]           in_year,
    input  logic [drtfl_pkg::MONTH_W-1:0]          in_month,
    input  logic [drtfl_pkg::DAY_W-1:0]            in_day,
    input  logic [drtfl_pkg::AMOUNT_W-1:0]         in_amount,
    input  logic                                   cfg_we,
    input  logic [drtfl_pkg::LIMIT_W-1:0]          cfg_data,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic [drtfl_pkg::STATUS_W-1:0]         out_status,
    output logic [drtfl_pkg::PROD_W-1:0]           out_product,
    input  drtfl_pkg::cmd_t                        cmd,
    output drtfl_pkg::sts_t                        sts
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int MAG_W  = drtfl_pkg::AMOUNT_W - 1;
    localparam int CMP_W  = drtfl_pkg::LIMIT_W + FRACTION_BITS + drtfl_pkg::AMOUNT_W;
    localparam int ACC_W  = 96;
    localparam int KEY_W  = drtfl_pkg::KEY_W;
    localparam int AMT_W  = drtfl_pkg::AMOUNT_W;
    // floor(y / 25) as (y * 20972) >> 19, exact for all 14 bit years
    localparam logic [14:0] DIV25_MUL = 15'd20972;
    localparam int          DIV25_SH  = 19;

    logic [drtfl_pkg::ENTRY_W-1:0] mem [TABLE_ENTRIES];
    logic [drtfl_pkg::ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic [IDX_W-1:0]              wr_addr;
    logic [drtfl_pkg::ENTRY_W-1:0] wr_data;
    logic                          wr_en;

    logic                          op_reg;
    logic [drtfl_pkg::YEAR_W-1:0]  year_reg;
    logic [drtfl_pkg::MONTH_W-1:0] month_reg;
    logic [drtfl_pkg::DAY_W-1:0]   day_reg;
    logic [AMT_W-1:0]              amt_reg;
    logic [drtfl_pkg::LIMIT_W-1:0] limit_reg;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              lo_reg;
    logic [CNT_W-1:0]              hi_reg;
    logic [CNT_W-1:0]              sh_reg;
    logic                          dup_reg;
    logic [AMT_W-1:0]              rate_reg;

    logic [2:0]                    mul_cnt_reg;
    logic [63:0]                   pp_reg;
    logic [ACC_W-1:0]              acc_reg;

    logic                          out_valid_reg;
    logic [drtfl_pkg::STATUS_W-1:0] out_status_reg;
    logic [drtfl_pkg::PROD_W-1:0]  out_product_reg;

    logic [KEY_W-1:0]              key;
    logic [CNT_W:0]                mid_sum;
    logic [CNT_W-1:0]              mid;
    logic [KEY_W-1:0]              rd_key;
    logic [AMT_W-1:0]              rd_rate;
    logic [28:0]                   y_mul;
    logic [drtfl_pkg::YEAR_W-1:0]  y_q25;
    logic [drtfl_pkg::YEAR_W-1:0]  y_r25;
    logic                          leap;
    logic [4:0]                    maxd;
    logic                          date_ok;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [ACC_W-1:0]              scaled;
    logic [drtfl_pkg::PROD_W-1:0]  sat_product;

    assign key     = {year_reg, month_reg[3:0], day_reg[4:0]};
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign rd_key  = rd_data_reg[drtfl_pkg::ENTRY_W-1:AMT_W];
    assign rd_rate = rd_data_reg[AMT_W-1:0];

    // leap year without a divider
    assign y_mul = 29'(year_reg) * 29'(DIV25_MUL);
    assign y_q25 = drtfl_pkg::YEAR_W'(y_mul >> DIV25_SH);
    assign y_r25 = year_reg - drtfl_pkg::YEAR_W'(y_q25 * 14'd25);
    assign leap  = (year_reg[1:0] == 2'd0) && ((y_r25 != '0) || (year_reg[3:0] == 4'd0));
    always_comb
    begin
        maxd = drtfl_pkg::month_len(month_reg[3:0]);
        if (month_reg == 7'd2 && leap)
        begin
            maxd = 5'd29;
        end
    end
    assign date_ok = (month_reg >= 7'd1) && (month_reg <= 7'd12) &&
                     (day_reg >= 7'd1) && (day_reg <= 7'(maxd));

    assign sts.bad_date   = !date_ok;
    assign sts.negative   = amt_reg[AMT_W-1];
    assign sts.too_large  = CMP_W'(amt_reg[MAG_W-1:0]) > (CMP_W'(limit_reg) << FRACTION_BITS);
    assign sts.full       = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign sts.is_query   = (op_reg == drtfl_pkg::OP_QUERY);
    assign sts.srch_done  = (lo_reg == hi_reg);
    assign sts.dup        = dup_reg;
    assign sts.found      = (lo_reg != '0);
    assign sts.shift_done = (sh_reg == lo_reg);
    assign sts.mul_done   = (mul_cnt_reg == 3'd5);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    // table memory, one write and one registered read a cycle
    always_comb
    begin
        rd_addr = mid[IDX_W-1:0];
        if (cmd.sh_rd)
        begin
            rd_addr = IDX_W'(sh_reg - CNT_W'(1));
        end
        wr_en   = cmd.sh_wr || cmd.ins_wr;
        wr_addr = cmd.ins_wr ? lo_reg[IDX_W-1:0] : sh_reg[IDX_W-1:0];
        wr_data = cmd.ins_wr ? {key, amt_reg} : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // partial products of two 47 bit magnitudes, 32 bit halves
    always_comb
    begin
        unique case (mul_cnt_reg)
            3'd0:
            begin
                mul_a = amt_reg[31:0];
                mul_b = rate_reg[31:0];
            end
            3'd1:
            begin
                mul_a = amt_reg[31:0];
                mul_b = 32'(rate_reg[MAG_W-1:32]);
            end
            3'd2:
            begin
                mul_a = 32'(amt_reg[MAG_W-1:32]);
                mul_b = rate_reg[31:0];
            end
            3'd3:
            begin
                mul_a = 32'(amt_reg[MAG_W-1:32]);
                mul_b = 32'(rate_reg[MAG_W-1:32]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign scaled      = acc_reg >> FRACTION_BITS;
    assign sat_product = (scaled[ACC_W-1:63] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : scaled[63:0];

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_opcode;
            year_reg  <= in_year;
            month_reg <= in_month;
            day_reg   <= in_day;
            amt_reg   <= in_amount;
        end
        if (cmd.srch_init)
        begin
            lo_reg  <= '0;
            hi_reg  <= count_reg;
            dup_reg <= 1'b0;
        end
        else if (cmd.srch_cmp)
        begin
            if (rd_key <= key)
            begin
                lo_reg   <= mid + CNT_W'(1);
                rate_reg <= rd_rate;
                dup_reg  <= (rd_key == key);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        if (cmd.sh_init)
        begin
            sh_reg <= count_reg;
        end
        else if (cmd.sh_wr)
        begin
            sh_reg <= sh_reg - CNT_W'(1);
        end
        if (cmd.mul_init)
        begin
            mul_cnt_reg <= '0;
            acc_reg     <= '0;
        end
        else if (cmd.mul_step)
        begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
            pp_reg      <= mul_a * mul_b;
            unique case (mul_cnt_reg)
                3'd1:    acc_reg <= acc_reg + ACC_W'(pp_reg);
                3'd2,
                3'd3:    acc_reg <= acc_reg + (ACC_W'(pp_reg) << 32);
                3'd4:    acc_reg <= acc_reg + (ACC_W'(pp_reg) << 64);
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.emit)
        begin
            out_status_reg  <= cmd.status;
            out_product_reg <= cmd.prod_en ? sat_product : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            limit_reg     <= drtfl_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_product = out_product_reg;

endmodule

>>> rtl/dated_rate_table_floor_lookup.sv
`timescale 1ns / 1ps

// Dated rate table: requests either insert a rate at a calendar date or look up the
// latest rate at or before a date and return amount times rate (16 fraction bits,
// saturated). One request is worked at a time. The search over the sorted table
// reads and then compares each probe through the single read port of the table
// memory. A query then works in the multiply state: five steps on the shared 32x32
// multiplier and one to finish. An insert also moves every later entry up by one,
// each with a read and then a write, before the new entry is written. A request is
// rejected either at the date, sign or limit check or after the search (no prior
// entry, duplicate date, full table). The next request is taken in the idle state
// after the result is emitted. A result may wait in the output register while the
// next request is taken.
module dated_rate_table_floor_lookup #(
    parameter int TABLE_ENTRIES = drtfl_pkg::TABLE_ENTRIES_DEF,
    parameter int FRACTION_BITS = drtfl_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    drtfl_in_if.sink    in_ch,
    drtfl_out_if.source out_ch,
    drtfl_cfg_if.sink   cfg
);

    drtfl_pkg::cmd_t cmd;
    drtfl_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    drtfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    drtfl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_opcode   (in_ch.opcode),
        .in_year     (in_ch.year),
        .in_month    (in_ch.month),
        .in_day      (in_ch.day),
        .in_amount   (in_ch.amount),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.query_limit),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_status  (out_ch.status),
        .out_product (out_ch.product),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

>>> tb/tb_ifs.sv
`timescale 1ns / 1ps

// the block's channel interfaces come with the rtl; nothing extra is needed here
package tb_ifs_pkg;
    localparam int RESET_CYCLES = 9;
endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TBL_N = 4096;
    localparam int FRAC = 16;
    localparam longint CYCLE_LIMIT = 20000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;

    drtfl_in_if  in_ch();
    drtfl_out_if out_ch();
    drtfl_cfg_if cfg();

    dated_rate_table_floor_lookup dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
    );

    always #6 clk = ~clk;

    typedef struct {
        logic [drtfl_pkg::STATUS_W-1:0] status;
        logic [drtfl_pkg::PROD_W-1:0]   product;
    } rate_result_t;

    class rate_scoreboard;
        bit [drtfl_pkg::KEY_W-1:0]    keys[$];
        bit [drtfl_pkg::AMOUNT_W-1:0] rates[$];
        bit [drtfl_pkg::LIMIT_W-1:0]  limit_reg;
        rate_result_t                 pending[$];
        int                           errors;

        function new();
            limit_reg = drtfl_pkg::LIMIT_RESET;
            errors = 0;
        endfunction

        function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
            int unsigned mlen;
            if (m < 1 || m > 12 || d < 1 || d > 31)
                return 0;
            unique case (m)
                4, 6, 9, 11: mlen = 30;
                2:           mlen = 28;
                default:     mlen = 31;
            endcase
            if (m == 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0))
                mlen = 29;
            return d <= mlen;
        endfunction

        function void note_request(bit op, bit [drtfl_pkg::YEAR_W-1:0] y,
                                   bit [drtfl_pkg::MONTH_W-1:0] m,
                                   bit [drtfl_pkg::DAY_W-1:0] d,
                                   bit [drtfl_pkg::AMOUNT_W-1:0] amt);
            rate_result_t r;
            bit [drtfl_pkg::KEY_W-1:0] key;
            bit [127:0] full;
            int pos;
            r.status = drtfl_pkg::ST_OK;
            r.product = '0;
            if (!date_valid(y, m, d))
                r.status = drtfl_pkg::ST_BAD_DATE;
            else if (amt[drtfl_pkg::AMOUNT_W-1])
                r.status = drtfl_pkg::ST_NEGATIVE;
            else
            begin
                key = {y, m[3:0], d[4:0]};
                pos = 0;
                while (pos < keys.size() && keys[pos] <= key)
                    pos++;
                if (op == drtfl_pkg::OP_INSERT)
                begin
                    if (pos > 0 && keys[pos-1] == key)
                        r.status = drtfl_pkg::ST_DUPLICATE;
                    else if (keys.size() >= TBL_N)
                        r.status = drtfl_pkg::ST_FULL;
                    else
                    begin
                        keys.insert(pos, key);
                        rates.insert(pos, amt);
                    end
                end
                else if (64'(amt) > (64'(limit_reg) << FRAC))
                    r.status = drtfl_pkg::ST_TOO_LARGE;
                else if (pos == 0)
                    r.status = drtfl_pkg::ST_NO_PRIOR;
                else
                begin
                    full = (128'(amt) * 128'(rates[pos-1])) >> FRAC;
                    r.product = (full > 128'h7FFF_FFFF_FFFF_FFFF) ?
                                64'h7FFF_FFFF_FFFF_FFFF : full[63:0];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [drtfl_pkg::STATUS_W-1:0] st,
                                   logic [drtfl_pkg::PROD_W-1:0] pr);
            rate_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result status=%0d product=%0h", st, pr);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (pr !== e.product)
            begin
                $error("product: expected %0h, got %0h", e.product, pr);
                errors++;
            end
        endfunction
    endclass

    rate_scoreboard sb = new();

    initial
    begin
        in_ch.valid = 1'b0; in_ch.opcode = 1'b0; in_ch.year = '0;
        in_ch.month = '0; in_ch.day = '0; in_ch.amount = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0; cfg.query_limit = '0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stalls per request
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.status, out_ch.product);
                stall_left = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) stall_left = 0;
            end
            else if (stall_left > 0)
                stall_left--;
            out_ch.ready <= (stall_left == 0);
        end
    end

    // valid stays high after a request is taken until the next gap or drain
    task automatic send_request(bit op, bit [drtfl_pkg::YEAR_W-1:0] y,
                                bit [drtfl_pkg::MONTH_W-1:0] m,
                                bit [drtfl_pkg::DAY_W-1:0] d,
                                bit [drtfl_pkg::AMOUNT_W-1:0] amt, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1; in_ch.opcode <= op; in_ch.year <= y;
        in_ch.month <= m; in_ch.day <= d; in_ch.amount <= amt;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_request(op, y, m, d, amt);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(bit [drtfl_pkg::LIMIT_W-1:0] v);
        cfg.valid <= 1'b1; cfg.query_limit <= v;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.limit_reg = v;
    endtask

    // dates mostly valid, drawn from a narrow span so queries hit entries
    task automatic random_request(int ins_pct, int amt_bits);
        bit op;
        bit [drtfl_pkg::YEAR_W-1:0] y;
        bit [drtfl_pkg::MONTH_W-1:0] m;
        bit [drtfl_pkg::DAY_W-1:0] d;
        bit [drtfl_pkg::AMOUNT_W-1:0] amt;
        op = ($urandom_range(0, 99) >= ins_pct);
        y = ($urandom_range(0, 9) == 0) ? drtfl_pkg::YEAR_W'($urandom_range(0, 16383)) :
                                          drtfl_pkg::YEAR_W'($urandom_range(1998, 2002));
        m = drtfl_pkg::MONTH_W'($urandom_range(1, 12));
        d = drtfl_pkg::DAY_W'($urandom_range(1, 28));
        case ($urandom_range(0, 19))
            0: m = drtfl_pkg::MONTH_W'($urandom_range(0, 127));
            1: d = drtfl_pkg::DAY_W'($urandom_range(0, 127));
            2:
            begin
                m = 7'd2;
                d = 7'd29;
            end
            3: d = drtfl_pkg::DAY_W'($urandom_range(29, 31));
            default: ;
        endcase
        amt = drtfl_pkg::AMOUNT_W'({$urandom, $urandom});
        amt = amt >> (drtfl_pkg::AMOUNT_W - amt_bits);
        if ($urandom_range(0, 19) == 0) amt[drtfl_pkg::AMOUNT_W-1] = 1'b1;
        if ($urandom_range(0, 29) == 0) amt = '0;
        send_request(op, y, m, d, amt);
    endtask

    initial
    begin
        repeat (tb_ifs_pkg::RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, date checks, extremes
        send_request(drtfl_pkg::OP_QUERY, 2000, 1, 1, 48'h10000);
        send_request(drtfl_pkg::OP_INSERT, 2000, 2, 29, 48'h20000);
        send_request(drtfl_pkg::OP_INSERT, 1900, 2, 29, 48'h20000);
        send_request(drtfl_pkg::OP_INSERT, 2004, 2, 29, 48'h0);
        send_request(drtfl_pkg::OP_INSERT, 2100, 2, 28, 48'h7FFF_FFFF_FFFF);
        send_request(drtfl_pkg::OP_INSERT, 2000, 0, 5, 48'h1);
        send_request(drtfl_pkg::OP_INSERT, 2000, 13, 5, 48'h1);
        send_request(drtfl_pkg::OP_INSERT, 2000, 4, 31, 48'h1);
        send_request(drtfl_pkg::OP_INSERT, 2000, 5, 0, 48'h1);
        send_request(drtfl_pkg::OP_INSERT, 16383, 127, 127, 48'hFFFF_FFFF_FFFF);
        send_request(drtfl_pkg::OP_INSERT, 16383, 12, 31, 48'h8000_0000_0000);
        send_request(drtfl_pkg::OP_INSERT, 0, 1, 1, 48'h18000);
        send_request(drtfl_pkg::OP_INSERT, 2000, 2, 29, 48'h30000);
        send_request(drtfl_pkg::OP_QUERY, 2000, 2, 29, 48'h3E8_0000);
        send_request(drtfl_pkg::OP_QUERY, 2000, 2, 29, 48'h3E8_0001);
        send_request(drtfl_pkg::OP_QUERY, 1999, 12, 31, 48'hFFFF_FFFF_FFFF);
        send_request(drtfl_pkg::OP_QUERY, 2050, 6, 15, 48'h12345);
        send_request(drtfl_pkg::OP_QUERY, 16383, 12, 31, 48'h0);
        drain();
        write_limit('1);
        send_request(drtfl_pkg::OP_QUERY, 2100, 2, 28, 48'hF_FFFF_0000);
        send_request(drtfl_pkg::OP_QUERY, 2100, 3, 1, 48'h7FFF_FFFF_FFFF);
        send_request(drtfl_pkg::OP_QUERY, 9999, 12, 31, 48'h1);
        drain();
        write_limit('0);
        send_request(drtfl_pkg::OP_QUERY, 2000, 3, 1, 48'h0);
        send_request(drtfl_pkg::OP_QUERY, 2000, 3, 1, 48'h1);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: write_limit(20'd1000);
                1: write_limit(drtfl_pkg::LIMIT_W'($urandom_range(1, 1048575)));
                2: write_limit(20'd0);
                default: write_limit(20'hFFFFF);
            endcase
            for (int i = 0; i < 400; i++)
            begin
                random_request((ph == 0) ? 50 : 30, (i % 3 == 0) ? 48 : 37);
                if (ph == 1 && i == 200)
                begin
                    in_ch.valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
            drain();
        end

        // back-to-back burst with no sender gaps
        for (int i = 0; i < 60; i++)
            send_request(i[0], 2001, 6, drtfl_pkg::DAY_W'((i % 28) + 1), 48'h1_8000, 1'b1);
        drain();

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

>>> dated_rate_table_floor_lookup.f
rtl/drtfl_pkg.sv
rtl/drtfl_in_if.sv
rtl/drtfl_out_if.sv
rtl/drtfl_cfg_if.sv
rtl/drtfl_ctrl.sv
rtl/drtfl_dp.sv
rtl/dated_rate_table_floor_lookup.sv
tb/tb_ifs.sv
tb/tb.sv
